### rtl/poly_function_generator_gate_macros.svh
// Assertion macros used by the gate generator controller
`ifndef POLY_FUNCTION_GENERATOR_GATE_MACROS_SVH
`define POLY_FUNCTION_GENERATOR_GATE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset
`define PFG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define PFG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/pfg_pkg.sv
// Types, constants and helpers of the gate generator
package pfg_pkg;

  localparam int VOICES      = 4;
  localparam int SEQ_LEN     = 5;
  localparam int SCALE_STEPS = 13;
  localparam int VIDX_W      = $clog2(VOICES);
  localparam int SIDX_W      = 3;

  localparam logic [15:0] Q15_ONE   = 16'd32768;
  localparam logic [15:0] SEQ_PEAK  = 16'd27853;
  localparam logic [15:0] GRAB_PEAK = 16'd328;
  localparam logic [6:0]  BASE_NOTE = 7'd45;

  localparam logic [2:0] CMD_TICK    = 3'd0;
  localparam logic [2:0] CMD_TRIG    = 3'd1;
  localparam logic [2:0] CMD_GRAB    = 3'd2;
  localparam logic [2:0] CMD_MOVE    = 3'd3;
  localparam logic [2:0] CMD_RELEASE = 3'd4;
  localparam logic [2:0] CMD_REPITCH = 3'd5;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_RISE = 2'd1;
  localparam logic [1:0] PH_FALL = 2'd2;

  localparam logic [1:0] MODE_TREM   = 2'd1;
  localparam logic [1:0] MODE_TIMBRE = 2'd2;

  localparam logic [2:0] REG_RISE   = 3'd0;
  localparam logic [2:0] REG_FALL   = 3'd1;
  localparam logic [2:0] REG_PERIOD = 3'd2;
  localparam logic [2:0] REG_TIMBRE = 3'd3;
  localparam logic [2:0] REG_MODE   = 3'd4;
  localparam logic [2:0] REG_RUN    = 3'd5;
  localparam logic [2:0] REG_USESEQ = 3'd6;
  localparam logic [2:0] REG_STEPS  = 3'd7;

  typedef struct packed {
    logic [15:0] rise_step;
    logic [15:0] fall_step;
    logic [11:0] pulse_period;
    logic [15:0] timbre_base;
    logic [1:0]  cycle_mode;
    logic        run_enable;
    logic        use_sequence;
    logic [19:0] sequence_steps;
  } pfg_cfg_t;

  typedef struct packed {
    logic              load;
    logic              do_cmd;
    logic              do_pulse;
    logic              do_step;
    logic              do_lfo;
    logic              do_emit;
    logic [VIDX_W-1:0] idx;
  } pfg_ctl_t;

  typedef struct packed {
    logic out_free;
    logic out_valid;
  } pfg_sts_t;

  function automatic logic [15:0] sat_q15(logic [16:0] v);
    return (v > {1'b0, Q15_ONE}) ? Q15_ONE : v[15:0];
  endfunction

  function automatic logic [6:0] step_note(logic [3:0] s);
    logic [3:0] sc;
    logic [3:0] rem;
    logic [6:0] oct;
    logic [6:0] pent;
    sc = (s > 4'(SCALE_STEPS - 1)) ? 4'(SCALE_STEPS - 1) : s;
    if (sc >= 4'd10) begin
      oct = 7'd24;
      rem = sc - 4'd10;
    end else if (sc >= 4'd5) begin
      oct = 7'd12;
      rem = sc - 4'd5;
    end else begin
      oct = 7'd0;
      rem = sc;
    end
    case (rem)
      4'd1:    pent = 7'd2;
      4'd2:    pent = 7'd4;
      4'd3:    pent = 7'd7;
      4'd4:    pent = 7'd9;
      default: pent = 7'd0;
    endcase
    return BASE_NOTE + oct + pent;
  endfunction

endpackage

### rtl/pfg_ctrl.sv
// Sequencer that walks a command through its command step, and a tick through pulser, voice, LFO and emit steps
module pfg_ctrl
  import pfg_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [2:0]     cmd_i,
  output logic           in_stall_o,
  input  pfg_sts_t       sts_i,
  output pfg_ctl_t       ctl_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CMD   = 3'd1;
  localparam logic [2:0] S_PULSE = 3'd2;
  localparam logic [2:0] S_STEP  = 3'd3;
  localparam logic [2:0] S_LFO   = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  localparam logic [VIDX_W-1:0] LAST_IDX = VIDX_W'(VOICES - 1);

  logic [2:0]        state_q, state_d;
  logic [VIDX_W-1:0] idx_q, idx_d;
  logic              accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    ctl_o   = '0;
    ctl_o.idx = idx_q;
    unique case (state_q)
      S_IDLE: begin
        ctl_o.load = accept;
        if (accept) begin
          state_d = (cmd_i == CMD_TICK) ? S_PULSE : S_CMD;
        end
      end
      S_CMD: begin
        ctl_o.do_cmd = 1'b1;
        state_d = S_IDLE;
      end
      S_PULSE: begin
        ctl_o.do_pulse = 1'b1;
        idx_d   = '0;
        state_d = S_STEP;
      end
      S_STEP: begin
        ctl_o.do_step = 1'b1;
        if (idx_q == LAST_IDX) begin
          state_d = S_LFO;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_LFO: begin
        ctl_o.do_lfo = 1'b1;
        idx_d   = '0;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        // hold until the output register can take the item
        if (sts_i.out_free) begin
          ctl_o.do_emit = 1'b1;
          if (idx_q == LAST_IDX) begin
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

`include "poly_function_generator_gate_macros.svh"

  `PFG_ASSERT_NEXT(a_tick_to_pulse, accept && (cmd_i == CMD_TICK), state_q == S_PULSE, "tick did not start the pulser")
  `PFG_ASSERT_NEXT(a_emit_hold, (state_q == S_EMIT) && !sts_i.out_free, $stable(idx_q) && (state_q == S_EMIT), "emit advanced while output full")
  `PFG_ASSERT_NEXT(a_last_emit_idle, ctl_o.do_emit && (idx_q == LAST_IDX), (state_q == S_IDLE) && sts_i.out_valid, "last result not followed by idle")

endmodule

### rtl/pfg_dp.sv
// Voice, pulser and LFO state with the output register
module pfg_dp
  import pfg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  pfg_cfg_t    cfg_i,
  input  pfg_ctl_t    ctl_i,
  output pfg_sts_t    sts_o,
  input  logic [2:0]  cmd_i,
  input  logic [6:0]  pitch_i,
  input  logic [15:0] velocity_i,
  input  logic [15:0] pressure_i,
  input  logic [1:0]  voice_select_i,
  input  logic [3:0]  random_step_i,
  input  logic [15:0] random_velocity_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  voice_o,
  output logic [6:0]  note_o,
  output logic [15:0] gate_level_o,
  output logic [15:0] timbre_o,
  output logic        last_o
);

  localparam logic [VIDX_W-1:0] LAST_IDX = VIDX_W'(VOICES - 1);

  logic [15:0] level_q [VOICES];
  logic [1:0]  phase_q [VOICES];
  logic [15:0] peak_q  [VOICES];
  logic [6:0]  vpitch_q[VOICES];
  logic [15:0] lfo_q;
  logic        lfo_rising_q;
  logic [12:0] pulse_acc_q;
  logic [SIDX_W-1:0] seq_index_q;
  logic        press_active_q;
  logic [VIDX_W-1:0] press_voice_q;
  logic [15:0] press_target_q;

  logic [2:0]  cmd_q;
  logic [6:0]  pitch_q;
  logic [15:0] vel_q, pres_q, rvel_q;
  logic [1:0]  vsel_q;
  logic [3:0]  rstep_q;

  logic        out_valid_q;
  logic [1:0]  voice_q;
  logic [6:0]  note_q;
  logic [15:0] gate_q, timbre_q;
  logic        last_q;

  // quietest voice, ties to lowest index
  logic [VIDX_W-1:0] sel;
  always_comb begin
    sel = '0;
    for (int i = 1; i < VOICES; i++) begin
      if (level_q[i] < level_q[sel]) sel = VIDX_W'(i);
    end
  end

  // pulser
  logic [13:0] acc1, acc2;
  logic        fire;
  logic [12:0] acc_nx;
  logic [19:0] seq_sh;
  logic [6:0]  pl_note;
  logic [15:0] pl_peak;
  always_comb begin
    acc1   = {1'b0, pulse_acc_q} + 14'd16;
    fire   = acc1 >= {2'b00, cfg_i.pulse_period};
    acc2   = acc1 - {2'b00, cfg_i.pulse_period};
    if (!fire) acc_nx = acc1[12:0];
    else if (acc2 > {2'b00, cfg_i.pulse_period}) acc_nx = {1'b0, cfg_i.pulse_period};
    else acc_nx = acc2[12:0];
    seq_sh = cfg_i.sequence_steps >> {seq_index_q, 2'b00};
    if (cfg_i.use_sequence) begin
      pl_note = step_note(seq_sh[3:0]);
      pl_peak = SEQ_PEAK;
    end else begin
      pl_note = step_note(rstep_q);
      pl_peak = sat_q15({1'b0, rvel_q});
    end
  end

  // envelope step of the addressed voice
  logic [16:0] lv, lv_nx, diff;
  logic [1:0]  ph_nx;
  always_comb begin
    lv    = {1'b0, level_q[ctl_i.idx]};
    lv_nx = lv;
    ph_nx = phase_q[ctl_i.idx];
    diff  = '0;
    if (press_active_q && (ctl_i.idx == press_voice_q)) begin
      if ({1'b0, press_target_q} > lv) begin
        diff  = {1'b0, press_target_q} - lv;
        lv_nx = (diff > {1'b0, cfg_i.rise_step}) ? lv + {1'b0, cfg_i.rise_step}
                                                  : {1'b0, press_target_q};
      end else begin
        diff  = lv - {1'b0, press_target_q};
        lv_nx = (diff > {1'b0, cfg_i.fall_step}) ? lv - {1'b0, cfg_i.fall_step}
                                                  : {1'b0, press_target_q};
      end
    end else if (phase_q[ctl_i.idx] == PH_RISE) begin
      lv_nx = lv + {1'b0, cfg_i.rise_step};
      if (lv_nx >= {1'b0, peak_q[ctl_i.idx]}) begin
        lv_nx = {1'b0, peak_q[ctl_i.idx]};
        ph_nx = PH_FALL;
      end
    end else if (phase_q[ctl_i.idx] == PH_FALL) begin
      if (lv <= {1'b0, cfg_i.fall_step}) begin
        lv_nx = '0;
        ph_nx = PH_IDLE;
      end else begin
        lv_nx = lv - {1'b0, cfg_i.fall_step};
      end
    end
  end

  // LFO step
  logic [16:0] lfo_sum;
  logic [15:0] lfo_nx;
  logic        lfo_rise_nx;
  always_comb begin
    lfo_sum     = {1'b0, lfo_q} + {1'b0, cfg_i.rise_step};
    lfo_nx      = lfo_q;
    lfo_rise_nx = lfo_rising_q;
    if (lfo_rising_q) begin
      if (lfo_sum >= {1'b0, Q15_ONE}) begin
        lfo_nx      = Q15_ONE;
        lfo_rise_nx = 1'b0;
      end else begin
        lfo_nx = lfo_sum[15:0];
      end
    end else if (lfo_q <= cfg_i.fall_step) begin
      lfo_nx      = '0;
      lfo_rise_nx = 1'b1;
    end else begin
      lfo_nx = lfo_q - cfg_i.fall_step;
    end
  end

  // result of the addressed voice
  logic [17:0] t3;
  logic [15:0] trem;
  logic [16:0] tim17;
  logic [31:0] prod;
  logic [32:0] prod_r;
  always_comb begin
    t3     = {2'b00, lfo_q} + {1'b0, lfo_q, 1'b0} + 18'd2;
    trem   = (cfg_i.cycle_mode == MODE_TREM) ? 16'd8192 + t3[17:2] : Q15_ONE;
    tim17  = {1'b0, cfg_i.timbre_base};
    if (cfg_i.cycle_mode == MODE_TIMBRE) begin
      tim17 = tim17 + (({1'b0, lfo_q} + 17'd1) >> 1);
    end
    prod   = level_q[ctl_i.idx] * trem;
    prod_r = {1'b0, prod} + 33'd16384;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < VOICES; i++) begin
        level_q[i]  <= '0;
        phase_q[i]  <= PH_IDLE;
        peak_q[i]   <= Q15_ONE;
        vpitch_q[i] <= BASE_NOTE;
      end
      lfo_q          <= '0;
      lfo_rising_q   <= 1'b1;
      pulse_acc_q    <= '0;
      seq_index_q    <= '0;
      press_active_q <= 1'b0;
      press_voice_q  <= '0;
      press_target_q <= '0;
    end else begin
      if (ctl_i.do_cmd) begin
        case (cmd_q)
          CMD_TRIG: begin
            vpitch_q[sel] <= pitch_q;
            phase_q[sel]  <= PH_RISE;
            peak_q[sel]   <= sat_q15({1'b0, vel_q});
          end
          CMD_GRAB: begin
            // a regrab of the held voice leaves it idle
            if (press_active_q && (press_voice_q != sel)) begin
              phase_q[press_voice_q] <= PH_FALL;
            end
            vpitch_q[sel]  <= pitch_q;
            phase_q[sel]   <= PH_IDLE;
            peak_q[sel]    <= GRAB_PEAK;
            press_voice_q  <= sel;
            press_active_q <= 1'b1;
            press_target_q <= sat_q15({1'b0, pres_q});
          end
          CMD_MOVE: begin
            if (press_active_q) begin
              press_target_q          <= sat_q15({1'b0, pres_q});
              vpitch_q[press_voice_q] <= pitch_q;
            end
          end
          CMD_RELEASE: begin
            if (press_active_q) begin
              phase_q[press_voice_q] <= PH_FALL;
              press_active_q         <= 1'b0;
            end
          end
          CMD_REPITCH: begin
            if ({1'b0, vsel_q} < 3'(VOICES)) vpitch_q[vsel_q[VIDX_W-1:0]] <= pitch_q;
          end
          default: ;
        endcase
      end
      if (ctl_i.do_pulse && cfg_i.run_enable) begin
        pulse_acc_q <= acc_nx;
        if (fire) begin
          vpitch_q[sel] <= pl_note;
          phase_q[sel]  <= PH_RISE;
          peak_q[sel]   <= pl_peak;
          if (cfg_i.use_sequence) begin
            seq_index_q <= (seq_index_q == SIDX_W'(SEQ_LEN - 1)) ? '0 : seq_index_q + 1'b1;
          end
        end
      end
      if (ctl_i.do_step) begin
        level_q[ctl_i.idx] <= sat_q15(lv_nx);
        phase_q[ctl_i.idx] <= ph_nx;
      end
      if (ctl_i.do_lfo) begin
        lfo_q        <= lfo_nx;
        lfo_rising_q <= lfo_rise_nx;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q   <= cmd_i;
      pitch_q <= pitch_i;
      vel_q   <= velocity_i;
      pres_q  <= pressure_i;
      vsel_q  <= voice_select_i;
      rstep_q <= random_step_i;
      rvel_q  <= random_velocity_i;
    end
    if (ctl_i.do_emit) begin
      voice_q  <= 2'(ctl_i.idx);
      note_q   <= vpitch_q[ctl_i.idx];
      gate_q   <= sat_q15(prod_r[31:15]);
      timbre_q <= sat_q15(tim17);
      last_q   <= (ctl_i.idx == LAST_IDX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.do_emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.out_free  = !out_valid_q || !out_stall_i;
  assign sts_o.out_valid = out_valid_q;
  assign out_valid_o  = out_valid_q;
  assign voice_o      = voice_q;
  assign note_o       = note_q;
  assign gate_level_o = gate_q;
  assign timbre_o     = timbre_q;
  assign last_o       = last_q;

endmodule

### rtl/poly_function_generator_gate.sv
// Four-voice gate generator: usage
// Input channel (in_valid_i / in_stall_o) takes one command item: tick, trigger,
// press grab, press move, press release or repitch. Only a tick yields results:
// one item per voice, voice 0 first, last_o high on the final voice.
// Output channel (out_valid_o / out_stall_i) carries voice, note, gate level and
// timbre from a single output register.
// Sequence: a non-tick command is accepted, then applied in the command state. A
// tick is accepted, then walks the pulser state, an envelope step for each voice,
// the LFO state and an emit step for each voice. The sequencer updates one voice
// per cycle, except that emit waits while the output register is full.
// in_stall_o stays high until the item is fully handled; the next item may be taken
// while the final result still waits in the output register.
// A stalled receiver holds the output register and freezes the emit walk.
// Reset clears all voices to idle at level 0, pitch 45 and peak full scale, the LFO
// to zero and rising, and loads the register defaults.
// Registers sit on an APB port at byte address 4 times the register index.
module poly_function_generator_gate
  import pfg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  cmd_i,
  input  logic [6:0]  pitch_i,
  input  logic [15:0] velocity_i,
  input  logic [15:0] pressure_i,
  input  logic [1:0]  voice_select_i,
  input  logic [3:0]  random_step_i,
  input  logic [15:0] random_velocity_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  voice_o,
  output logic [6:0]  note_o,
  output logic [15:0] gate_level_o,
  output logic [15:0] timbre_o,
  output logic        last_o
);

  pfg_cfg_t   cfg_q;
  pfg_ctl_t   ctl;
  pfg_sts_t   sts;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rise_step      <= 16'd14077;
      cfg_q.fall_step      <= 16'd857;
      cfg_q.pulse_period   <= 12'd461;
      cfg_q.timbre_base    <= 16'd14746;
      cfg_q.cycle_mode     <= 2'd0;
      cfg_q.run_enable     <= 1'b0;
      cfg_q.use_sequence   <= 1'b1;
      cfg_q.sequence_steps <= 20'd336928;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_RISE:   cfg_q.rise_step      <= pwdata[15:0];
        REG_FALL:   cfg_q.fall_step      <= pwdata[15:0];
        REG_PERIOD: cfg_q.pulse_period   <= pwdata[11:0];
        REG_TIMBRE: cfg_q.timbre_base    <= pwdata[15:0];
        REG_MODE:   cfg_q.cycle_mode     <= pwdata[1:0];
        REG_RUN:    cfg_q.run_enable     <= pwdata[0];
        REG_USESEQ: cfg_q.use_sequence   <= pwdata[0];
        REG_STEPS:  cfg_q.sequence_steps <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_RISE:   prdata = {16'd0, cfg_q.rise_step};
      REG_FALL:   prdata = {16'd0, cfg_q.fall_step};
      REG_PERIOD: prdata = {20'd0, cfg_q.pulse_period};
      REG_TIMBRE: prdata = {16'd0, cfg_q.timbre_base};
      REG_MODE:   prdata = {30'd0, cfg_q.cycle_mode};
      REG_RUN:    prdata = {31'd0, cfg_q.run_enable};
      REG_USESEQ: prdata = {31'd0, cfg_q.use_sequence};
      REG_STEPS:  prdata = {12'd0, cfg_q.sequence_steps};
      default:    prdata = '0;
    endcase
  end

  pfg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  pfg_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .ctl_i             (ctl),
    .sts_o             (sts),
    .cmd_i             (cmd_i),
    .pitch_i           (pitch_i),
    .velocity_i        (velocity_i),
    .pressure_i        (pressure_i),
    .voice_select_i    (voice_select_i),
    .random_step_i     (random_step_i),
    .random_velocity_i (random_velocity_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .voice_o           (voice_o),
    .note_o            (note_o),
    .gate_level_o      (gate_level_o),
    .timbre_o          (timbre_o),
    .last_o            (last_o)
  );

endmodule

### dv/poly_function_generator_gate_tb.sv
// Self-checking testbench for the four-voice gate generator
module poly_function_generator_gate_tb;
  import pfg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  cmd_i = '0;
  logic [6:0]  pitch_i = '0;
  logic [15:0] velocity_i = '0, pressure_i = '0, random_velocity_i = '0;
  logic [1:0]  voice_select_i = '0;
  logic [3:0]  random_step_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  voice_o;
  logic [6:0]  note_o;
  logic [15:0] gate_level_o, timbre_o;
  logic        last_o;

  poly_function_generator_gate dut (.*);

  always #5 clk_i = ~clk_i;

  typedef struct packed {
    logic [1:0]  voice;
    logic [6:0]  note;
    logic [15:0] gate_level;
    logic [15:0] timbre;
    logic        last;
  } voice_out_t;

  voice_out_t gate_q[$];
  int errors = 0;
  int ticks_sent = 0;
  int results_seen = 0;
  int cycles = 0;

  // predictor state
  pfg_cfg_t    cfg;
  logic [16:0] lvl [VOICES];
  logic [1:0]  phase [VOICES];
  logic [15:0] peak [VOICES];
  logic [6:0]  vpitch [VOICES];
  logic [16:0] lfo;
  logic        lfo_up;
  logic [12:0] pacc;
  logic [2:0]  seq_idx;
  logic        pressing;
  logic [1:0]  press_v;
  logic [15:0] press_tgt;

  function automatic logic [15:0] clamp1(int unsigned v);
    return (v > 32768) ? 16'd32768 : 16'(v);
  endfunction

  function automatic logic [6:0] scale_note(int unsigned s);
    int unsigned pent[5] = '{0, 2, 4, 7, 9};
    if (s > SCALE_STEPS - 1) s = SCALE_STEPS - 1;
    return 7'(45 + 12 * (s / 5) + pent[s % 5]);
  endfunction

  function automatic int steal_voice(logic [6:0] nt, logic [15:0] pk);
    int v = 0;
    for (int i = 1; i < VOICES; i++) if (lvl[i] < lvl[v]) v = i;
    vpitch[v] = nt;
    phase[v] = PH_RISE;
    peak[v] = pk;
    return v;
  endfunction

  task automatic model_reset();
    for (int v = 0; v < VOICES; v++) begin
      lvl[v] = 0; phase[v] = PH_IDLE; peak[v] = Q15_ONE; vpitch[v] = BASE_NOTE;
    end
    lfo = 0; lfo_up = 1; pacc = 0; seq_idx = 0;
    pressing = 0; press_v = 0; press_tgt = 0;
    cfg = '{rise_step: 16'd14077, fall_step: 16'd857, pulse_period: 12'd461,
            timbre_base: 16'd14746, cycle_mode: 2'd0, run_enable: 1'b0,
            use_sequence: 1'b1, sequence_steps: 20'd336928};
  endtask

  task automatic gate_predict(logic [2:0] c, logic [6:0] p, logic [15:0] vel,
                              logic [15:0] prs, logic [1:0] sel, logic [3:0] rs,
                              logic [15:0] rv);
    int v;
    int unsigned l, trem, tim, g, r, f;
    r = cfg.rise_step; f = cfg.fall_step;
    case (c)
      CMD_TRIG: v = steal_voice(p, clamp1(vel));
      CMD_GRAB: begin
        if (pressing) phase[press_v] = PH_FALL;
        v = steal_voice(p, GRAB_PEAK);
        phase[v] = PH_IDLE;
        press_v = 2'(v); pressing = 1; press_tgt = clamp1(prs);
      end
      CMD_MOVE: if (pressing) begin
        press_tgt = clamp1(prs); vpitch[press_v] = p;
      end
      CMD_RELEASE: if (pressing) begin
        phase[press_v] = PH_FALL; pressing = 0;
      end
      CMD_REPITCH: vpitch[sel] = p;
      CMD_TICK: begin
        if (cfg.run_enable) begin
          pacc = pacc + 13'd16;
          if (pacc >= cfg.pulse_period) begin
            pacc = pacc - cfg.pulse_period;
            if (pacc > cfg.pulse_period) pacc = cfg.pulse_period;
            if (cfg.use_sequence) begin
              v = steal_voice(scale_note((cfg.sequence_steps >> (4 * seq_idx)) & 15),
                              SEQ_PEAK);
              seq_idx = (seq_idx + 1) % SEQ_LEN;
            end else v = steal_voice(scale_note(rs), clamp1(rv));
          end
        end
        for (int i = 0; i < VOICES; i++) begin
          l = lvl[i];
          if (pressing && i == press_v) begin
            if (press_tgt > l) l = (press_tgt - l > r) ? l + r : press_tgt;
            else l = (l - press_tgt > f) ? l - f : press_tgt;
          end else if (phase[i] == PH_RISE) begin
            l = l + r;
            if (l >= peak[i]) begin l = peak[i]; phase[i] = PH_FALL; end
          end else if (phase[i] == PH_FALL) begin
            if (l <= f) begin l = 0; phase[i] = PH_IDLE; end
            else l = l - f;
          end
          lvl[i] = clamp1(l);
        end
        l = lfo;
        if (lfo_up) begin
          l = l + r;
          if (l >= 32768) begin l = 32768; lfo_up = 0; end
        end else if (l <= f) begin l = 0; lfo_up = 1; end
        else l = l - f;
        lfo = l;
        trem = (cfg.cycle_mode == MODE_TREM) ? 8192 + ((3 * l + 2) >> 2) : 32768;
        tim = cfg.timbre_base + ((cfg.cycle_mode == MODE_TIMBRE) ? ((l + 1) >> 1) : 0);
        for (int i = 0; i < VOICES; i++) begin
          g = (lvl[i] * trem + 16384) >> 15;
          gate_q.push_back('{2'(i), vpitch[i], clamp1(g), clamp1(tim),
                             i == VOICES - 1});
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_item(logic [2:0] c, logic [6:0] p, logic [15:0] vel,
                           logic [15:0] prs, logic [1:0] sel, logic [3:0] rs,
                           logic [15:0] rv);
    @(posedge clk_i);
    in_valid_i <= 1'b1;
    cmd_i <= c; pitch_i <= p; velocity_i <= vel; pressure_i <= prs;
    voice_select_i <= sel; random_step_i <= rs; random_velocity_i <= rv;
    // stall only changes at the rising edge, so sample it in between
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    @(posedge clk_i);
    gate_predict(c, p, vel, prs, sel, rs, rv);
    if (c == CMD_TICK) ticks_sent++;
    in_valid_i <= 1'b0;
  endtask

  // random bursts with random gaps
  int burst_left = 0;
  task automatic send_paced(logic [2:0] c, logic [6:0] p, logic [15:0] vel,
                            logic [15:0] prs, logic [1:0] sel, logic [3:0] rs,
                            logic [15:0] rv);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      repeat ($urandom_range(0, 6)) @(posedge clk_i);
    end
    burst_left--;
    send_item(c, p, vel, prs, sel, rs, rv);
  endtask

  task automatic tick();
    send_paced(CMD_TICK, 7'($urandom), 16'($urandom), 16'($urandom), 2'($urandom),
               4'($urandom_range(0, 15)), 16'($urandom));
  endtask

  task automatic drain();
    while (gate_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_RISE:   cfg.rise_step = val[15:0];
      REG_FALL:   cfg.fall_step = val[15:0];
      REG_PERIOD: cfg.pulse_period = val[11:0];
      REG_TIMBRE: cfg.timbre_base = val[15:0];
      REG_MODE:   cfg.cycle_mode = val[1:0];
      REG_RUN:    cfg.run_enable = val[0];
      REG_USESEQ: cfg.use_sequence = val[0];
      default:    cfg.sequence_steps = val[19:0];
    endcase
  endtask

  task automatic test_directed();
    send_item(CMD_TICK, 0, 0, 0, 0, 0, 0);
    send_item(CMD_TRIG, 7'd127, 16'hFFFF, 0, 0, 0, 0);
    send_item(CMD_TRIG, 7'd0, 16'd32768, 0, 0, 0, 0);
    send_item(CMD_MOVE, 7'd10, 0, 16'd500, 0, 0, 0);
    send_item(CMD_RELEASE, 0, 0, 0, 0, 0, 0);
    send_item(CMD_GRAB, 7'd60, 0, 16'hFFFF, 0, 0, 0);
    send_item(CMD_TICK, 0, 0, 0, 0, 0, 0);
    send_item(CMD_GRAB, 7'd61, 0, 16'd100, 0, 0, 0);
    send_item(CMD_MOVE, 7'd62, 0, 16'd0, 0, 0, 0);
    send_item(CMD_TRIG, 7'd70, 16'd1, 0, 0, 0, 0);
    send_item(CMD_TICK, 0, 0, 0, 0, 0, 0);
    send_item(CMD_REPITCH, 7'd100, 0, 0, 2'd3, 0, 0);
    send_item(CMD_REPITCH, 7'd1, 0, 0, 2'd0, 0, 0);
    send_item(3'd6, 7'h55, 16'hFFFF, 16'hFFFF, 2'd3, 4'hF, 16'hFFFF);
    send_item(3'd7, 7'h2A, 16'h5555, 16'hAAAA, 2'd1, 4'h5, 16'hAAAA);
    send_item(CMD_RELEASE, 0, 0, 0, 0, 0, 0);
    repeat (4) send_item(CMD_TICK, 0, 0, 0, 0, 0, 0);
    drain();
  endtask

  task automatic test_registers();
    write_reg(REG_RISE, 32'd32768);
    write_reg(REG_FALL, 32'd1);
    write_reg(REG_PERIOD, 32'd1);
    write_reg(REG_TIMBRE, 32'd32768);
    write_reg(REG_MODE, 32'd2);
    write_reg(REG_RUN, 32'd1);
    write_reg(REG_USESEQ, 32'd1);
    write_reg(REG_STEPS, 32'hFFFFF);
    repeat (6) tick();
    drain();
    write_reg(REG_RISE, 32'd0);
    write_reg(REG_FALL, 32'd0);
    write_reg(REG_PERIOD, 32'd4095);
    write_reg(REG_TIMBRE, 32'd0);
    write_reg(REG_MODE, 32'd1);
    write_reg(REG_STEPS, 32'h0C5A3);
    repeat (4) tick();
    drain();
  endtask

  task automatic random_phase(int n);
    int unsigned k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 50) tick();
      else if (k < 60) send_paced(CMD_TRIG, 7'($urandom), 16'($urandom), 0, 0, 0, 0);
      else if (k < 68) send_paced(CMD_GRAB, 7'($urandom), 0, 16'($urandom), 0, 0, 0);
      else if (k < 78) send_paced(CMD_MOVE, 7'($urandom), 0,
                                  16'($urandom_range(0, 32768)), 0, 0, 0);
      else if (k < 85) send_paced(CMD_RELEASE, 0, 0, 0, 0, 0, 0);
      else if (k < 95) send_paced(CMD_REPITCH, 7'($urandom), 0, 0, 2'($urandom), 0, 0);
      else send_paced(3'($urandom_range(6, 7)), 7'($urandom), 16'($urandom),
                      16'($urandom), 2'($urandom), 4'($urandom), 16'($urandom));
      // hold off once until the output side has caught up
      if (i == n / 2) while (gate_q.size() != 0) @(posedge clk_i);
    end
    drain();
  endtask

  task automatic test_random();
    write_reg(REG_RISE, $urandom_range(500, 9000));
    write_reg(REG_FALL, $urandom_range(200, 4000));
    write_reg(REG_PERIOD, $urandom_range(17, 80));
    write_reg(REG_TIMBRE, $urandom_range(0, 32768));
    write_reg(REG_MODE, 32'd1);
    write_reg(REG_USESEQ, 32'd0);
    random_phase(40);
    write_reg(REG_MODE, 32'd2);
    write_reg(REG_USESEQ, 32'd1);
    write_reg(REG_STEPS, $urandom_range(0, 20'hFFFFF));
    write_reg(REG_PERIOD, $urandom_range(1, 40));
    random_phase(40);
    write_reg(REG_MODE, 32'd0);
    write_reg(REG_RISE, 32'd32768);
    write_reg(REG_FALL, 32'd32768);
    write_reg(REG_RUN, 32'd0);
    random_phase(40);
  endtask

  // receiver stall pattern: runs of free and stalled cycles
  initial begin
    int run;
    forever begin
      run = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 5);
      repeat (run) @(posedge clk_i);
      out_stall_i <= ($urandom_range(0, 2) == 0);
    end
  end

  always @(posedge clk_i) begin
    voice_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (gate_q.size() == 0) begin
        errors++;
        $error("result with nothing expected: voice %0d", voice_o);
      end else begin
        want = gate_q.pop_front();
        if (voice_o !== want.voice) begin
          errors++; $error("voice: expected %0d got %0d", want.voice, voice_o);
        end
        if (note_o !== want.note) begin
          errors++; $error("note: expected %0d got %0d", want.note, note_o);
        end
        if (gate_level_o !== want.gate_level) begin
          errors++;
          $error("gate_level: expected %0d got %0d", want.gate_level, gate_level_o);
        end
        if (timbre_o !== want.timbre) begin
          errors++; $error("timbre: expected %0d got %0d", want.timbre, timbre_o);
        end
        if (last_o !== want.last) begin
          errors++; $error("last: expected %0d got %0d", want.last, last_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    model_reset();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_registers();
    test_random();
    if (gate_q.size() != 0) begin
      errors++; $error("%0d results never arrived", gate_q.size());
    end
    $display("covered %0d ticks and %0d voice results over directed, register and random",
             ticks_sent, results_seen);
    $display("phases with tremolo, timbre LFO, sequence and random pulser modes");
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
